[rtl/core/mbrws_pkg.sv]
// Shared types, constants and the CRC-16/Modbus byte fold for the
// write-single-register slave. No dependencies.
`default_nettype none

package mbrws_pkg;

    localparam int FRAME_MAX_DEF = 256;
    localparam int HDR_BYTES     = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int TX_IDX_W      = 3;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  FUNC_WRITE_REG = 8'h06;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;
    localparam logic [15:0] REG_FIRST      = 16'h0004;
    localparam logic [15:0] REG_LAST       = 16'h0007;
    localparam logic [15:0] VAL_MAX        = 16'h0001;

    // Body lengths of the two response kinds, CRC bytes not counted
    localparam logic [TX_IDX_W-1:0] BODY_EXC  = 3'd3;
    localparam logic [TX_IDX_W-1:0] BODY_ECHO = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAD_FUNCTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAD_ADDRESS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BAD_VALUE    = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [3:0] output_bits;
    } rsp_t;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] code_bad_function;
        logic [7:0] code_bad_address;
        logic [7:0] code_bad_value;
    } cfg_t;

    // Finished frame: header bytes and the length/overflow/CRC verdict
    typedef struct packed {
        logic                           valid;
        logic                           ok;
        logic [HDR_BYTES-1:0][7:0]      hdr;
    } sum_t;

    // Response to send: body bytes, kind and output bits after the frame
    typedef struct packed {
        logic                           valid;
        logic                           echo;
        logic [HDR_BYTES-1:0][7:0]      body;
        logic [3:0]                     led;
    } load_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mbrws_frame_acc.sv]
// Receive side: running CRC, header and tail capture, byte count, overflow.
// Hands one summary per frame to the decoder. Depends on mbrws_pkg.
`default_nettype none

module mbrws_frame_acc #(
    parameter int FRAME_MAX = mbrws_pkg::FRAME_MAX_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire mbrws_pkg::req_t req,
    output mbrws_pkg::sum_t     sum,
    input  wire logic           sum_take
);
    import mbrws_pkg::*;

    localparam int CNT_W = $clog2(FRAME_MAX + 1);
    localparam logic [CNT_W-1:0] FRAME_LIM = CNT_W'(FRAME_MAX);

    logic [15:0]               crc_reg, crc_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [HDR_BYTES-1:0][7:0] hdr_reg, hdr_next;
    logic [1:0][7:0]           tail_reg, tail_next;
    logic                      ovf_reg, ovf_next;
    sum_t                      sum_reg, sum_next;
    logic                      accept;

    // Hold a frame-end byte while the previous summary is still waiting
    assign req_ready = !req.frame_end || !sum_reg.valid || sum_take;
    assign accept    = req_valid && req_ready;
    assign sum       = sum_reg;

    always_comb
    begin
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        hdr_next  = hdr_reg;
        tail_next = tail_reg;
        ovf_next  = ovf_reg;
        sum_next  = sum_reg;
        if (sum_take)
        begin
            sum_next.valid = 1'b0;
        end
        if (accept)
        begin
            if (cnt_reg >= FRAME_LIM)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    if (cnt_reg == CNT_W'(i))
                    begin
                        hdr_next[i] = req.rx_byte;
                    end
                end
                // Fold the byte leaving the two-byte tail window
                if (cnt_reg >= CNT_W'(2))
                begin
                    crc_next = crc_fold(crc_reg, tail_reg[0]);
                end
                tail_next[0] = tail_reg[1];
                tail_next[1] = req.rx_byte;
                cnt_next     = CNT_W'(cnt_reg + 1'b1);
            end
            if (req.frame_end)
            begin
                sum_next.valid = 1'b1;
                sum_next.hdr   = hdr_next;
                sum_next.ok    = !ovf_next && (cnt_next >= CNT_W'(4))
                                 && (tail_next[0] == crc_next[7:0])
                                 && (tail_next[1] == crc_next[15:8]);
                crc_next  = CRC_INIT;
                cnt_next  = '0;
                hdr_next  = '0;
                tail_next = '0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            cnt_reg  <= '0;
            hdr_reg  <= '0;
            tail_reg <= '0;
            ovf_reg  <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            hdr_reg  <= hdr_next;
            tail_reg <= tail_next;
            ovf_reg  <= ovf_next;
            sum_reg  <= sum_next;
        end
    end

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FRAME_LIM)
        else $error("byte count past frame limit");

    a_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg.valid && !sum_take |=> sum_reg.valid)
        else $error("frame summary lost before decode");

endmodule

`default_nettype wire

[rtl/core/mbrws_decode.sv]
// Frame decoder: address, function, register and value checks, output bit
// register, response body build. Depends on mbrws_pkg.
`default_nettype none

module mbrws_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mbrws_pkg::sum_t sum,
    input  wire mbrws_pkg::cfg_t cfg,
    input  wire logic            take,
    output mbrws_pkg::load_t     load
);
    import mbrws_pkg::*;

    logic [3:0]  led_reg, led_next, led_upd;
    logic [15:0] reg_addr, reg_val;
    logic        respond, fn_ok, reg_ok, val_ok, good;
    logic [7:0]  exc_func, exc_code;

    assign reg_addr = {sum.hdr[2], sum.hdr[3]};
    assign reg_val  = {sum.hdr[4], sum.hdr[5]};
    assign respond  = sum.valid && sum.ok && (sum.hdr[0] == cfg.slave_address);
    assign fn_ok    = sum.hdr[1] == FUNC_WRITE_REG;
    assign reg_ok   = (reg_addr >= REG_FIRST) && (reg_addr <= REG_LAST);
    assign val_ok   = reg_val <= VAL_MAX;
    assign good     = fn_ok && reg_ok && val_ok;

    // Bad function first, then bad register, then bad value
    assign exc_func = fn_ok ? (FUNC_WRITE_REG | EXC_FLAG) : (sum.hdr[1] | EXC_FLAG);
    assign exc_code = !fn_ok  ? cfg.code_bad_function :
                      !reg_ok ? cfg.code_bad_address  : cfg.code_bad_value;

    always_comb
    begin
        led_upd = led_reg;
        led_upd[reg_addr[1:0]] = reg_val[0];
        led_next = (take && respond && good) ? led_upd : led_reg;
    end

    always_comb
    begin
        load.valid   = respond;
        load.echo    = good;
        load.body    = '0;
        load.body[0] = cfg.slave_address;
        if (good)
        begin
            load.body[1] = FUNC_WRITE_REG;
            load.body[2] = sum.hdr[2];
            load.body[3] = sum.hdr[3];
            load.body[4] = sum.hdr[4];
            load.body[5] = sum.hdr[5];
            load.led     = led_upd;
        end
        else
        begin
            load.body[1] = exc_func;
            load.body[2] = exc_code;
            load.led     = led_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg <= '0;
        end
        else
        begin
            led_reg <= led_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mbrws_tx_ser.sv]
// Response serializer: holds one body, sends a byte per cycle unless stalled,
// while folding the CRC, then appends CRC low and high. Depends on mbrws_pkg.
`default_nettype none

module mbrws_tx_ser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mbrws_pkg::load_t load,
    output logic                  take,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output mbrws_pkg::rsp_t       rsp
);
    import mbrws_pkg::*;

    logic                      busy_reg, busy_next;
    logic [TX_IDX_W-1:0]       idx_reg, idx_next;
    logic                      echo_reg, echo_next;
    logic [HDR_BYTES-1:0][7:0] body_reg, body_next;
    logic [3:0]                led_reg, led_next;
    logic [15:0]               crc_reg, crc_next;
    logic                      out_valid_reg, out_valid_next;
    rsp_t                      out_reg, out_next;

    logic [TX_IDX_W-1:0] body_len;
    logic                step, in_body, last;
    logic [7:0]          body_byte, tx_sel;

    assign take      = !busy_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign body_len = echo_reg ? BODY_ECHO : BODY_EXC;
    assign step     = busy_reg && (!out_valid_reg || rsp_ready);
    assign in_body  = idx_reg < body_len;
    assign last     = idx_reg == TX_IDX_W'(body_len + 1'b1);

    always_comb
    begin
        body_byte = '0;
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            if (idx_reg == TX_IDX_W'(i))
            begin
                body_byte = body_reg[i];
            end
        end
        if (in_body)
        begin
            tx_sel = body_byte;
        end
        else if (idx_reg == body_len)
        begin
            tx_sel = crc_reg[7:0];
        end
        else
        begin
            tx_sel = crc_reg[15:8];
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        echo_next      = echo_reg;
        body_next      = body_reg;
        led_next       = led_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next       = 1'b1;
            out_next.tx_byte     = tx_sel;
            out_next.tx_last     = last;
            out_next.output_bits = led_reg;
            if (in_body)
            begin
                crc_next = crc_fold(crc_reg, body_byte);
            end
            idx_next = TX_IDX_W'(idx_reg + 1'b1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
        // Load the next response once the buffer is free
        if (take && load.valid)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            crc_next  = CRC_INIT;
            echo_next = load.echo;
            body_next = load.body;
            led_next  = load.led;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg <= echo_next;
        body_reg <= body_next;
        led_reg  <= led_next;
        crc_reg  <= crc_next;
        out_reg  <= out_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= TX_IDX_W'(body_len + 1'b1))
        else $error("serializer index past response end");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> !busy_reg || (idx_reg == '0))
        else $error("serializer still busy after last byte");

endmodule

`default_nettype wire

[rtl/core/modbus_rtu_write_register_slave.sv]
// Top level of the write-single-register slave: configuration registers and
// the receive, decode and transmit parts. Depends on mbrws_pkg.
//
// Usage:
//   req channel (req_valid/req_ready, req) carries received frame bytes in
//   line order; frame_end marks the last byte. One byte can transfer every
//   cycle. A frame-end byte is held off only while the previous frame's
//   summary waits for the transmitter to free its buffer.
//   rsp channel (rsp_valid/rsp_ready, rsp) carries response bytes, CRC low
//   byte before high byte, tx_last on the final one, and the four output bits
//   as they stand after the frame.
//   After the frame-end transfer the first response byte passes the summary
//   register, the transmitter buffer load and the output register; the rest
//   follow one per cycle while rsp_ready holds, 5 bytes for an exception and
//   8 for an echo.
//   A stalled receiver holds the output register; the transmitter buffer
//   and the summary register keep taking work until both are full.
//   Reset clears frame state, output bits and the configuration registers to
//   address 1 and exception codes 1, 2, 3. Write configuration only while idle.
`default_nettype none

module modbus_rtu_write_register_slave #(
    parameter int FRAME_MAX = mbrws_pkg::FRAME_MAX_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [mbrws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                         cfg_wdata,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire mbrws_pkg::req_t                    req,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output mbrws_pkg::rsp_t                         rsp
);
    import mbrws_pkg::*;

    cfg_t  cfg_reg;
    sum_t  sum;
    load_t load;
    logic  take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address     <= 8'd1;
            cfg_reg.code_bad_function <= 8'd1;
            cfg_reg.code_bad_address  <= 8'd2;
            cfg_reg.code_bad_value    <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS:     cfg_reg.slave_address     <= cfg_wdata;
                CFG_CODE_BAD_FUNCTION: cfg_reg.code_bad_function <= cfg_wdata;
                CFG_CODE_BAD_ADDRESS:  cfg_reg.code_bad_address  <= cfg_wdata;
                CFG_CODE_BAD_VALUE:    cfg_reg.code_bad_value    <= cfg_wdata;
            endcase
        end
    end

    mbrws_frame_acc #(
        .FRAME_MAX (FRAME_MAX)
    ) u_frame_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .sum       (sum),
        .sum_take  (take)
    );

    mbrws_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .sum   (sum),
        .cfg   (cfg_reg),
        .take  (take),
        .load  (load)
    );

    mbrws_tx_ser u_tx_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .take      (take),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[test/modbus_rtu_write_register_slave_tb.sv]
// Self-checking testbench for the write-single-register slave: frames in on the
// req channel, response bytes checked against an in-bench predictor on the rsp channel.
// Depends on mbrws_pkg and modbus_rtu_write_register_slave.
module modbus_rtu_write_register_slave_tb;
    import mbrws_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_LONG      = 400;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RAND_BYTES     = 45;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_wdata;
    logic                 req_valid;
    logic                 req_ready;
    req_t                 req;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;

    // Predictor state and its copy of the configuration
    logic [7:0]  slave_addr_m;
    logic [7:0]  code_func_m;
    logic [7:0]  code_addr_m;
    logic [7:0]  code_val_m;
    logic [15:0] crc_m;
    int          count_m;
    logic [7:0]  hdr_m [HDR_BYTES];
    logic [7:0]  tail_m [2];
    logic        ovf_m;
    logic [3:0]  led_m;
    rsp_t        reply_q [$];

    logic idle_on;
    int   hold_left;
    int   errors;
    int   stall_count;
    int   frames_sent;
    int   bytes_sent;
    int   replies_checked;

    modbus_rtu_write_register_slave dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void clear_frame();
        crc_m   = CRC_INIT;
        count_m = 0;
        foreach (hdr_m[i])
            hdr_m[i] = 8'h00;
        tail_m[0] = 8'h00;
        tail_m[1] = 8'h00;
        ovf_m     = 1'b0;
    endfunction

    // Append n body bytes and the CRC pair to the expected replies
    function automatic void queue_reply(logic [7:0] body [HDR_BYTES], int n);
        logic [15:0] crc;
        rsp_t        r;
        crc = CRC_INIT;
        for (int i = 0; i < n + 2; i++)
        begin
            if (i < n)
            begin
                r.tx_byte = body[i];
                crc = crc16_fold(crc, body[i]);
            end
            else
                r.tx_byte = (i == n) ? crc[7:0] : crc[15:8];
            r.tx_last     = (i == n + 1);
            r.output_bits = led_m;
            reply_q.push_back(r);
        end
    endfunction

    function automatic void finish_frame();
        logic [15:0] reg_addr;
        logic [15:0] reg_val;
        logic [7:0]  body [HDR_BYTES];
        foreach (body[i])
            body[i] = hdr_m[i];
        body[0] = slave_addr_m;
        reg_addr = {hdr_m[2], hdr_m[3]};
        reg_val  = {hdr_m[4], hdr_m[5]};
        if (ovf_m || count_m < 4)
            return;
        if (tail_m[0] != crc_m[7:0] || tail_m[1] != crc_m[15:8])
            return;
        if (hdr_m[0] != slave_addr_m)
            return;
        if (hdr_m[1] != FUNC_WRITE_REG)
        begin
            body[1] = hdr_m[1] | EXC_FLAG;
            body[2] = code_func_m;
            queue_reply(body, BODY_EXC);
        end
        else if (reg_addr < REG_FIRST || reg_addr > REG_LAST)
        begin
            body[1] = FUNC_WRITE_REG | EXC_FLAG;
            body[2] = code_addr_m;
            queue_reply(body, BODY_EXC);
        end
        else if (reg_val > VAL_MAX)
        begin
            body[1] = FUNC_WRITE_REG | EXC_FLAG;
            body[2] = code_val_m;
            queue_reply(body, BODY_EXC);
        end
        else
        begin
            led_m[reg_addr[1:0]] = reg_val[0];
            queue_reply(body, BODY_ECHO);
        end
    endfunction

    function automatic void absorb_rx_byte(req_t item);
        if (count_m >= FRAME_MAX_DEF)
            ovf_m = 1'b1;
        else
        begin
            if (count_m < HDR_BYTES)
                hdr_m[count_m] = item.rx_byte;
            if (count_m >= 2)
                crc_m = crc16_fold(crc_m, tail_m[0]);
            tail_m[0] = tail_m[1];
            tail_m[1] = item.rx_byte;
            count_m++;
        end
        if (item.frame_end)
        begin
            finish_frame();
            clear_frame();
        end
    endfunction

    function automatic void check_reply(rsp_t got);
        rsp_t want;
        if (reply_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected reply: byte %02h last %0b bits %01h",
                         got.tx_byte, got.tx_last, got.output_bits);
        end
        else
        begin
            want = reply_q.pop_front();
            replies_checked++;
            if (got.tx_byte !== want.tx_byte || got.tx_last !== want.tx_last ||
                got.output_bits !== want.output_bits)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("reply mismatch: expected byte %02h last %0b bits %01h",
                             want.tx_byte, want.tx_last, want.output_bits);
                    $display("                got      byte %02h last %0b bits %01h",
                             got.tx_byte, got.tx_last, got.output_bits);
                end
            end
        end
    endfunction

    // Predict on every req transfer, check every rsp transfer
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            absorb_rx_byte(req);
        if (rst_n && rsp_valid && rsp_ready)
            check_reply(rsp);
    end

    // Receiver: random idling, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= !(idle_on && ($urandom_range(0, 99) < 10));
    end

    initial
    begin
        stall_count = 0;
        while (stall_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic last);
        req_t item;
        item.rx_byte   = b;
        item.frame_end = last;
        if (idle_on && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(byte_q_t f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
        frames_sent++;
    endtask

    function automatic byte_q_t with_crc(byte_q_t body);
        logic [15:0] crc;
        byte_q_t     f;
        crc = CRC_INIT;
        f   = body;
        foreach (body[i])
            crc = crc16_fold(crc, body[i]);
        f.push_back(crc[7:0]);
        f.push_back(crc[15:8]);
        return f;
    endfunction

    function automatic byte_q_t build_write(logic [7:0] addr, logic [7:0] func,
                                            logic [15:0] reg_addr, logic [15:0] reg_val);
        byte_q_t f;
        f.push_back(addr);
        f.push_back(func);
        f.push_back(reg_addr[15:8]);
        f.push_back(reg_addr[7:0]);
        f.push_back(reg_val[15:8]);
        f.push_back(reg_val[7:0]);
        return f;
    endfunction

    task automatic send_write(logic [7:0] addr, logic [7:0] func,
                              logic [15:0] reg_addr, logic [15:0] reg_val);
        send_frame(with_crc(build_write(addr, func, reg_addr, reg_val)));
    endtask

    // Drop valid and let every expected reply drain before going on
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] addr, logic [7:0] fcode,
                              logic [7:0] acode, logic [7:0] vcode);
        wait_idle();
        cfg_put(CFG_SLAVE_ADDRESS, addr);
        cfg_put(CFG_CODE_BAD_FUNCTION, fcode);
        cfg_put(CFG_CODE_BAD_ADDRESS, acode);
        cfg_put(CFG_CODE_BAD_VALUE, vcode);
        cfg_we <= 1'b0;
        slave_addr_m = addr;
        code_func_m  = fcode;
        code_addr_m  = acode;
        code_val_m   = vcode;
        @(posedge clk);
    endtask

    task automatic test_echo_writes();
        send_write(slave_addr_m, FUNC_WRITE_REG, REG_FIRST, 16'h0001);
        send_write(slave_addr_m, FUNC_WRITE_REG, 16'h0005, 16'h0001);
        send_write(slave_addr_m, FUNC_WRITE_REG, REG_LAST, VAL_MAX);
        send_write(slave_addr_m, FUNC_WRITE_REG, REG_FIRST, 16'h0000);
        wait_idle();
    endtask

    task automatic test_exceptions();
        byte_q_t f;
        send_write(slave_addr_m, 8'h86, REG_FIRST, 16'h0001);
        send_write(slave_addr_m, FUNC_WRITE_REG, 16'h0104, 16'h0000);
        send_write(slave_addr_m, FUNC_WRITE_REG, 16'h0005, 16'h0100);
        // bad register and bad value together: register wins
        send_write(slave_addr_m, FUNC_WRITE_REG, 16'h0000, 16'hFFFF);
        // short headers with a good CRC: missing header bytes read as zero
        for (int len = 2; len <= 5; len += 3)
        begin
            f = build_write(slave_addr_m, FUNC_WRITE_REG, REG_FIRST, 16'h0001);
            while (f.size() > len)
                void'(f.pop_back());
            send_frame(with_crc(f));
        end
        wait_idle();
    endtask

    task automatic test_dropped_frames();
        byte_q_t f;
        send_write(slave_addr_m + 8'd1, FUNC_WRITE_REG, REG_FIRST, 16'h0001);
        f = with_crc(build_write(slave_addr_m, FUNC_WRITE_REG, REG_FIRST, 16'h0001));
        f[7] = f[7] ^ 8'h80;
        send_frame(f);
        // frames under four bytes, with and without a CRC
        f = {};
        f.push_back(slave_addr_m);
        send_frame(with_crc(f));
        for (int len = 1; len <= 3; len++)
        begin
            f = {};
            repeat (len) f.push_back(8'($urandom_range(0, 255)));
            send_frame(f);
        end
        send_write(slave_addr_m, FUNC_WRITE_REG, 16'h0007, 16'h0001);
        wait_idle();
    endtask

    task automatic probe_config();
        byte_q_t f;
        // four-byte frame: bad function answered from address and function alone
        f = {};
        f.push_back(slave_addr_m);
        f.push_back(8'h10);
        send_frame(with_crc(f));
        send_write(slave_addr_m, FUNC_WRITE_REG, 16'h0000, 16'h0000);
        send_write(slave_addr_m, FUNC_WRITE_REG, REG_LAST, 16'h0005);
    endtask

    task automatic test_config_settings();
        set_config(8'd247, 8'h00, 8'hFF, 8'h80);
        probe_config();
        set_config(8'd1, 8'hFF, 8'h00, 8'hFF);
        probe_config();
        wait_idle();
    endtask

    task automatic test_backpressure();
        logic saved_idle;
        saved_idle = idle_on;
        idle_on    = 1'b0;
        hold_left  = HOLD_LONG;
        // keep offering frames so the block fills up behind the stalled receiver
        for (int i = 0; i < 3; i++)
            send_write(slave_addr_m, FUNC_WRITE_REG, 16'(REG_FIRST + (i % 4)), 16'(i % 2));
        idle_on = saved_idle;
        wait_idle();
    endtask

    task automatic send_random_frame();
        byte_q_t     f;
        int          kind;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [15:0] reg_addr;
        logic [15:0] reg_val;
        kind = $urandom_range(0, 99);
        if (kind < 65)
        begin
            addr     = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : slave_addr_m;
            func     = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : FUNC_WRITE_REG;
            reg_addr = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'(REG_FIRST + $urandom_range(0, 3));
            reg_val  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 1));
            f = build_write(addr, func, reg_addr, reg_val);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4)) f.push_back(8'($urandom_range(0, 255)));
            f = with_crc(f);
            // corrupt one bit now and then
            if ($urandom_range(0, 11) == 0)
                f[$urandom_range(0, f.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        else if (kind < 82)
        begin
            f.push_back(slave_addr_m);
            repeat ($urandom_range(0, 4)) f.push_back(8'($urandom_range(0, 255)));
            f = with_crc(f);
        end
        else
        begin
            repeat ($urandom_range(1, 12)) f.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(f);
    endtask

    task automatic test_random_traffic();
        int start;
        set_config(8'($urandom_range(1, 247)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        start = bytes_sent;
        while (bytes_sent - start < RAND_BYTES / 3)
            send_random_frame();
        // long stretch with no idling on either side
        set_config(8'($urandom_range(1, 247)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        idle_on = 1'b0;
        start   = bytes_sent;
        while (bytes_sent - start < RAND_BYTES * 2 / 3)
            send_random_frame();
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SLAVE_ADDRESS;
        cfg_wdata <= 8'h00;
        req_valid <= 1'b0;
        req       <= '0;
        idle_on         = 1'b1;
        hold_left       = 0;
        errors          = 0;
        frames_sent     = 0;
        bytes_sent      = 0;
        replies_checked = 0;
        slave_addr_m = 8'd1;
        code_func_m  = 8'd1;
        code_addr_m  = 8'd2;
        code_val_m   = 8'd3;
        led_m        = 4'h0;
        clear_frame();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_echo_writes();
        test_exceptions();
        test_dropped_frames();
        test_config_settings();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        if (reply_q.size() != 0)
            errors += reply_q.size();
        $display("covered %0d frames (%0d bytes in): echoes, exceptions, silent drops,",
                 frames_sent, bytes_sent);
        $display("config extremes, a long receiver stall, random frames; %0d reply bytes, %0d errors",
                 replies_checked, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/mbrws_pkg.sv
rtl/core/mbrws_frame_acc.sv
rtl/core/mbrws_decode.sv
rtl/core/mbrws_tx_ser.sv
rtl/core/modbus_rtu_write_register_slave.sv
test/modbus_rtu_write_register_slave_tb.sv
